// ===== rtl/cht_pkg.sv =====
`default_nettype none

package cht_pkg;

  // Table geometry.
  localparam int BUCKETS      = 10;
  localparam int POOL_ENTRIES = 256;

  // Field widths of the request and response.
  localparam int KEY_W          = 31;
  localparam int PAYLOAD_W      = 64;
  localparam int BUCKET_FIELD_W = 4;

  // Derived widths for bucket indexes, entry pointers and the fill count.
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PTR_W  = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int USED_W = $clog2(POOL_ENTRIES + 1);

  // The bucket reduction takes the quotient of a key by the bucket count as
  // the upper part of the key times a rounded-up reciprocal. The rounding
  // error stays below one bucket count, so the quotient is exact for every key.
  localparam int MOD_SHIFT = KEY_W + $clog2(BUCKETS);
  localparam int RECIP_W   = KEY_W + 1;
  localparam logic [RECIP_W-1:0] MOD_RECIP =
    RECIP_W'(((64'd1 << MOD_SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

  // Operation codes.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                 func;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic [BUCKET_FIELD_W-1:0] bucket;
    logic [PAYLOAD_W-1:0]      found_payload;
  } rsp_t;

  // One pool entry as held in the entry memory.
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic                 link_vld;
    logic [PTR_W-1:0]     link;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/cht_ram.sv =====
`default_nettype none

module cht_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  // Synchronous write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Synchronous read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cht_mod.sv =====
`default_nettype none

// Reduces a key modulo the bucket count in two pipelined steps: a reciprocal
// multiply gives the quotient, then a subtract gives the remainder.
module cht_mod (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [cht_pkg::KEY_W-1:0]  key,
  output logic                            done,
  output logic      [cht_pkg::BKT_W-1:0]  rem
);

  localparam int PROD_W = cht_pkg::KEY_W + cht_pkg::RECIP_W;

  logic [cht_pkg::KEY_W-1:0] key_q;
  logic [cht_pkg::KEY_W-1:0] quot;
  logic                      mul_vld;
  logic                      sub_vld;
  logic [PROD_W-1:0]         prod;
  logic [cht_pkg::KEY_W-1:0] quot_next;
  logic [cht_pkg::BKT_W-1:0] rem_next;

  // The quotient is the upper part of the product. The remainder is below the
  // bucket count, so only the low bits of the subtraction are needed.
  always_comb begin
    prod      = PROD_W'(key_q) * PROD_W'(cht_pkg::MOD_RECIP);
    quot_next = cht_pkg::KEY_W'(prod >> cht_pkg::MOD_SHIFT);
    rem_next  = cht_pkg::BKT_W'(key_q) -
                cht_pkg::BKT_W'(quot) * cht_pkg::BKT_W'(cht_pkg::BUCKETS);
  end

  // Pipeline stages: key capture, quotient and remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld <= 1'b0;
      sub_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      mul_vld <= start;
      sub_vld <= mul_vld;
      done    <= sub_vld;
      if (start) begin
        key_q <= key;
      end
      if (mul_vld) begin
        quot <= quot_next;
      end
      if (sub_vld) begin
        rem <= rem_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/chained_hash_table_top.sv =====
`default_nettype none

// Hash table with separate chaining. A request is taken when start is high
// and busy is low; exactly one response follows, shown on rsp for a single
// cycle while done is high, and the receiver cannot hold it off. The bucket
// is computed with a reciprocal multiply and a subtract. An insert then
// updates the table and registers its response; a search of an empty
// bucket registers its response without a read; any other search issues
// the first chain read and walks the chain with one entry-memory read per
// entry until it finds the key or reaches the end of the chain.
// The pool holds 256 entries that are never freed; once it is full an insert
// stores nothing and reports pool full. Newer entries of a key shadow older
// ones. No clearing pass is needed after reset.
module chained_hash_table_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire cht_pkg::req_t req,
  output logic               done,
  output cht_pkg::rsp_t      rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_WALK
  } state_t;

  state_t state;

  cht_pkg::req_t                req_q;
  logic [cht_pkg::BKT_W-1:0]    bkt_q;
  logic [cht_pkg::USED_W-1:0]   used;
  logic [cht_pkg::PTR_W-1:0]    head_ptr [cht_pkg::BUCKETS];
  logic [cht_pkg::BUCKETS-1:0]  head_vld;

  logic                         mod_start;
  logic                         mod_done;
  logic [cht_pkg::BKT_W-1:0]    mod_rem;

  logic                         mem_we;
  logic                         mem_re;
  logic [cht_pkg::PTR_W-1:0]    mem_raddr;
  cht_pkg::entry_t              mem_wdata;
  cht_pkg::entry_t              mem_rdata;

  logic                         full;
  logic                         hit;

  assign busy      = (state != S_IDLE);
  assign mod_start = start && !busy;
  assign full      = (used == cht_pkg::USED_W'(cht_pkg::POOL_ENTRIES));
  assign hit       = (mem_rdata.key == req_q.key);

  cht_mod u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .key   (req.key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  cht_ram #(
    .DW ($bits(cht_pkg::entry_t)),
    .AW (cht_pkg::PTR_W)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (used[cht_pkg::PTR_W-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Entry memory control: insert writes the new entry, search follows links.
  always_comb begin
    mem_wdata.key      = req_q.key;
    mem_wdata.payload  = req_q.payload;
    mem_wdata.link_vld = head_vld[mod_rem];
    mem_wdata.link     = head_ptr[mod_rem];
    mem_we    = (state == S_HASH) && mod_done && (req_q.func == cht_pkg::FUNC_INSERT) && !full;
    mem_re    = 1'b0;
    mem_raddr = head_ptr[mod_rem];
    if ((state == S_HASH) && mod_done && (req_q.func == cht_pkg::FUNC_SEARCH) &&
        head_vld[mod_rem]) begin
      mem_re = 1'b1;
    end
    if ((state == S_WALK) && !hit && mem_rdata.link_vld) begin
      mem_re    = 1'b1;
      mem_raddr = mem_rdata.link;
    end
  end

  // Bucket head pointers move to the newly inserted entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      head_ptr[mod_rem] <= used[cht_pkg::PTR_W-1:0];
    end
  end

  // Request sequencing and the registered response.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      used     <= '0;
      head_vld <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            bkt_q <= mod_rem;
            if (req_q.func == cht_pkg::FUNC_INSERT) begin
              rsp.bucket        <= cht_pkg::BUCKET_FIELD_W'(mod_rem);
              rsp.found_payload <= '0;
              done              <= 1'b1;
              state             <= S_IDLE;
              if (full) begin
                rsp.status <= cht_pkg::ST_FULL;
              end else begin
                rsp.status        <= cht_pkg::ST_INSERTED;
                head_vld[mod_rem] <= 1'b1;
                used              <= used + cht_pkg::USED_W'(1);
              end
            end else if (head_vld[mod_rem]) begin
              state <= S_WALK;
            end else begin
              rsp.status        <= cht_pkg::ST_NOT_FOUND;
              rsp.bucket        <= cht_pkg::BUCKET_FIELD_W'(mod_rem);
              rsp.found_payload <= '0;
              done              <= 1'b1;
              state             <= S_IDLE;
            end
          end
        end
        S_WALK: begin
          // Read data holds the entry addressed in the previous cycle.
          if (hit) begin
            rsp.status        <= cht_pkg::ST_FOUND;
            rsp.bucket        <= cht_pkg::BUCKET_FIELD_W'(bkt_q);
            rsp.found_payload <= mem_rdata.payload;
            done              <= 1'b1;
            state             <= S_IDLE;
          end else if (!mem_rdata.link_vld) begin
            rsp.status        <= cht_pkg::ST_NOT_FOUND;
            rsp.bucket        <= cht_pkg::BUCKET_FIELD_W'(bkt_q);
            rsp.found_payload <= '0;
            done              <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
